/* sv/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and constants for the fit block allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int BLOCKS    = 32;
  localparam int IDX_W     = $clog2(BLOCKS);
  localparam int CNT_W     = $clog2(BLOCKS + 1);
  localparam int SIZE_W    = 16;
  localparam int MODE_W    = 2;
  localparam int BCOUNT_W  = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  // Stream payload widths, padded to whole bytes.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 24;

  // Fit policy codes.
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  // Input action codes.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_wr;  // write one table entry and clear its taken mark
    logic start;    // latch the request and restart the scan
    logic issue;    // read the entry at the scan counter
    logic finish;   // register the result and mark the pick taken if one was found
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;       // no entries take part
    logic last_issue;  // the current read is the last one
    logic out_free;    // the output register can take a result
  } stat_t;

endpackage

/* sv/fba_ctrl.sv */
// ----------------------------------------------------------------------------
// fba_ctrl
// Sequencer: accepts items, steps the scan and hands results to the output.
// ----------------------------------------------------------------------------
module fba_ctrl
  import fba_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  input  logic  s_tuser,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == ACT_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = stat.empty ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last entry read is compared in this cycle.
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/fba_datapath.sv */
// ----------------------------------------------------------------------------
// fba_datapath
// Size table, taken marks, scan counter, fit compare and output register.
// ----------------------------------------------------------------------------
module fba_datapath
  import fba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic [IDX_W-1:0]     block_index,
  input  logic [SIZE_W-1:0]    block_bytes,
  input  logic [SIZE_W-1:0]    request_bytes,
  input  logic [MODE_W-1:0]    fit_mode,
  input  logic [BCOUNT_W-1:0]  block_count,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser
);

  logic [SIZE_W-1:0] size_mem [BLOCKS];
  logic [BLOCKS-1:0] taken;

  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [SIZE_W-1:0] req;

  // Read stage.
  logic              vld_d;
  logic [IDX_W-1:0]  idx_d;
  logic              taken_d;
  logic [SIZE_W-1:0] rd_data;

  // Running pick.
  logic              found;
  logic [IDX_W-1:0]  pick;
  logic [SIZE_W-1:0] best;

  logic              cand;
  logic              take;
  logic [SIZE_W-1:0] rest;

  logic [IDX_W-1:0]  out_block;
  logic [SIZE_W-1:0] out_left;

  assign limit   = (BCOUNT_W'(block_count) > BCOUNT_W'(BLOCKS)) ? CNT_W'(BLOCKS)
                                                                  : CNT_W'(block_count);
  assign cnt_inc = cnt + CNT_W'(1);

  assign stat.empty      = (limit == '0);
  assign stat.last_issue = (cnt_inc >= limit);
  assign stat.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      size_mem[block_index] <= block_bytes;
    end
    rd_data <= size_mem[cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= request_bytes;
    end
    idx_d   <= cnt[IDX_W-1:0];
    taken_d <= taken[cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      vld_d <= 1'b0;
    end else if (cmd.start) begin
      cnt   <= '0;
      vld_d <= 1'b0;
    end else begin
      vld_d <= cmd.issue;
      if (cmd.issue) begin
        cnt <= cnt_inc;
      end
    end
  end

  // Ties keep the earlier index since only a strict improvement replaces it.
  always_comb begin
    rest = rd_data - req;
    cand = vld_d && !taken_d && (rd_data >= req);
    take = cand && (!found ||
                    ((fit_mode == MODE_BEST)  && (rest < best)) ||
                    ((fit_mode == MODE_WORST) && (rest > best)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pick <= idx_d;
      best <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else if (cmd.load_wr) begin
      taken[block_index] <= 1'b0;
    end else if (cmd.finish && found) begin
      taken[pick] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tuser   <= found;
      out_block <= found ? pick : '0;
      out_left  <= found ? best : '0;
    end
  end

  assign m_tdata = {(M_TDATA_W - IDX_W - SIZE_W)'(0), out_left, out_block};

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && found |-> !taken[pick])
    else $error("picked block is already taken");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("result not presented after finish");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    vld_d |-> (CNT_W'(idx_d) < limit))
    else $error("scan read beyond block count");

  a_nogrant_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata == '0))
    else $error("refused result carries nonzero fields");

endmodule

/* sv/fit_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// fit_block_allocator_core
// Fixed-block allocator with first, best or worst fit over a loaded table.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   s_*      in         s_tvalid/s_tready   tuser action; tdata index, size, request
//   m_*      out        m_tvalid/m_tready   tuser granted; tdata block, leftover
//   cfg_*    in         cfg_we              cfg_index selects register, cfg_data
//
// A load transfer writes the table entry and clears its taken mark, and the
// next item is accepted in the following cycle.
// A request scans limit entries, where limit is block_count capped at the
// table depth, one entry per cycle through the single read port of the size
// table, then drains and finishes; with no entries it goes straight to finish.
// Reset clears the taken marks, the registers and the output valid; the size
// table itself is not cleared and must be loaded before it is used.
// A finished result waits in the output register while the next item is
// accepted; a request that finishes while that register is still held stalls
// until the result ahead of it has been transferred.
//
module fit_block_allocator_core
  import fba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [4:0] block_index, [20:5] block_bytes, [36:21] request_bytes, rest zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [0] action
  input  logic                 s_tuser,

  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [4:0] chosen_block, [20:5] leftover, rest zero
  output logic [M_TDATA_W-1:0] m_tdata,
  // [0] granted
  output logic                 m_tuser,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [MODE_W-1:0]   fit_mode;
  logic [BCOUNT_W-1:0] block_count;

  cmd_t  cmd;
  stat_t stat;

  logic [IDX_W-1:0]  block_index;
  logic [SIZE_W-1:0] block_bytes;
  logic [SIZE_W-1:0] request_bytes;

  // Unpack the input payload.
  assign block_index   = s_tdata[IDX_W-1:0];
  assign block_bytes   = s_tdata[IDX_W +: SIZE_W];
  assign request_bytes = s_tdata[IDX_W + SIZE_W +: SIZE_W];

  // Configuration registers; writes are expected only while the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode    <= MODE_FIRST;
      block_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_MODE:    fit_mode    <= cfg_data[MODE_W-1:0];
        REG_BLOCK_COUNT: block_count <= cfg_data[BCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fba_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .block_index   (block_index),
    .block_bytes   (block_bytes),
    .request_bytes (request_bytes),
    .fit_mode      (fit_mode),
    .block_count   (block_count),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser)
  );

endmodule
